// ----- rtl/ktms_pkg.sv -----
// Shared widths, entry type and bank control bundle for the key/tag merge sorter.
// Depends on nothing; the RTL files other than the checker refer to it by scoped names.
`default_nettype none

package ktms_pkg;

  localparam int MAX_ITEMS = 64;
  localparam int ADDR_W    = $clog2(MAX_ITEMS);
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
  localparam int KEY_W     = 32;
  localparam int TAG_W     = 16;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic        [TAG_W-1:0] tag;
  } entry_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    entry_t            wdata;
    logic [ADDR_W-1:0] raddr_l;
    logic [ADDR_W-1:0] raddr_r;
  } bank_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/ktms_bank.sv -----
// One pair store: a single write port and two registered read ports.
// Depends on ktms_pkg for the entry type, depth and control bundle.
`default_nettype none

module ktms_bank (
  input  wire logic               clk,
  input  wire ktms_pkg::bank_ctl_t ctl,
  output ktms_pkg::entry_t        rd_l,
  output ktms_pkg::entry_t        rd_r
);

  ktms_pkg::entry_t mem [ktms_pkg::MAX_ITEMS];

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[ctl.waddr] <= ctl.wdata;
    end
    rd_l <= mem[ctl.raddr_l];
    rd_r <= mem[ctl.raddr_r];
  end

endmodule

`default_nettype wire

// ----- rtl/ktms_cmp.sv -----
// Shared signed key comparator used for every merge step.
// Depends on ktms_pkg for the key width.
`default_nettype none

module ktms_cmp (
  input  wire logic signed [ktms_pkg::KEY_W-1:0] key_l,
  input  wire logic signed [ktms_pkg::KEY_W-1:0] key_r,
  output logic                                   r_less
);

  assign r_less = key_r < key_l;

endmodule

`default_nettype wire

// ----- rtl/ktms_ctrl.sv -----
// Sequencer: load, bottom-up merge passes between two banks, and result emission.
// Depends on ktms_pkg and instantiates ktms_cmp.
`default_nettype none

module ktms_ctrl (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  input  wire logic signed [ktms_pkg::KEY_W-1:0] key,
  input  wire logic        [ktms_pkg::TAG_W-1:0] tag,
  input  wire logic                              final_item,
  output logic                                   busy,
  input  wire ktms_pkg::entry_t                  bank0_rd_l,
  input  wire ktms_pkg::entry_t                  bank0_rd_r,
  input  wire ktms_pkg::entry_t                  bank1_rd_l,
  input  wire ktms_pkg::entry_t                  bank1_rd_r,
  output ktms_pkg::bank_ctl_t                    bank0_ctl,
  output ktms_pkg::bank_ctl_t                    bank1_ctl,
  output logic                                   result_valid,
  output logic signed      [ktms_pkg::KEY_W-1:0] sorted_key,
  output logic             [ktms_pkg::TAG_W-1:0] sorted_tag,
  output logic                                   last_result,
  output logic                                   overflow
);

  localparam int CW = ktms_pkg::CNT_W;
  localparam int AW = ktms_pkg::ADDR_W;

  typedef enum logic [2:0] {
    S_LOAD,
    S_SETUP,
    S_MERGE,
    S_PASS,
    S_PRIME,
    S_EMIT
  } state_t;

  state_t          state, state_next;
  logic [CW-1:0]   count, count_next;
  logic            dropped, dropped_next;
  logic [CW-1:0]   n, n_next;
  logic [CW-1:0]   w, w_next;
  logic [CW-1:0]   b, b_next;
  logic [CW-1:0]   i, i_next;
  logic [CW-1:0]   j, j_next;
  logic [CW-1:0]   k, k_next;
  logic [CW-1:0]   left_end, left_end_next;
  logic [CW-1:0]   right_end, right_end_next;
  logic            src, src_next;

  logic                  result_valid_next;
  ktms_pkg::entry_t      out_next;
  logic                  last_result_next;
  logic                  overflow_next;

  logic [CW:0]     mid_sum, end_sum, n_ext;
  logic [CW-1:0]   mid, run_end;
  logic [CW-1:0]   count_inc, k_inc;
  logic            full, accept, left_ok, right_ok, r_less, take_r;
  logic [CW-1:0]   n_load;
  logic [AW-1:0]   ra_l, ra_r;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  ktms_pkg::entry_t wr_data, head_l, head_r;

  ktms_cmp u_cmp (
    .key_l  (head_l.key),
    .key_r  (head_r.key),
    .r_less (r_less)
  );

  assign busy      = (state != S_LOAD);
  assign head_l    = src ? bank1_rd_l : bank0_rd_l;
  assign head_r    = src ? bank1_rd_r : bank0_rd_r;
  assign n_ext     = {1'b0, n};
  assign mid_sum   = {1'b0, b} + {1'b0, w};
  assign end_sum   = {1'b0, b} + {w, 1'b0};
  assign mid       = (mid_sum > n_ext) ? n : mid_sum[CW-1:0];
  assign run_end   = (end_sum > n_ext) ? n : end_sum[CW-1:0];
  assign count_inc = count + CW'(1);
  assign k_inc     = k + CW'(1);
  assign full      = (count == CW'(ktms_pkg::MAX_ITEMS));
  assign accept    = start && (state == S_LOAD);
  assign n_load    = full ? count : count_inc;
  assign left_ok   = (i < left_end);
  assign right_ok  = (j < right_end);
  assign take_r    = right_ok && (!left_ok || r_less);

  always_comb begin
    state_next        = state;
    count_next        = count;
    dropped_next      = dropped;
    n_next            = n;
    w_next            = w;
    b_next            = b;
    i_next            = i;
    j_next            = j;
    k_next            = k;
    left_end_next     = left_end;
    right_end_next    = right_end;
    src_next          = src;
    result_valid_next = 1'b0;
    out_next          = head_l;
    last_result_next  = (k_inc == n);
    overflow_next     = dropped;
    ra_l              = '0;
    ra_r              = '0;
    wr_en             = 1'b0;
    wr_addr           = k[AW-1:0];
    wr_data           = take_r ? head_r : head_l;

    unique case (state)
      S_LOAD: begin
        wr_addr = count[AW-1:0];
        wr_data = '{key: key, tag: tag};
        if (accept) begin
          wr_en = !full;
          if (full) begin
            dropped_next = 1'b1;
          end else begin
            count_next = count_inc;
          end
          if (final_item) begin
            n_next     = n_load;
            w_next     = CW'(1);
            b_next     = '0;
            k_next     = '0;
            state_next = (n_load == CW'(1)) ? S_PRIME : S_SETUP;
          end
        end
      end
      S_SETUP: begin
        i_next         = b;
        j_next         = mid;
        left_end_next  = mid;
        right_end_next = run_end;
        ra_l           = b[AW-1:0];
        ra_r           = mid[AW-1:0];
        state_next     = S_MERGE;
      end
      S_MERGE: begin
        wr_en  = 1'b1;
        i_next = take_r ? i : i + CW'(1);
        j_next = take_r ? j + CW'(1) : j;
        ra_l   = i_next[AW-1:0];
        ra_r   = j_next[AW-1:0];
        k_next = k_inc;
        if (k_inc == right_end) begin
          b_next     = right_end;
          state_next = (right_end == n) ? S_PASS : S_SETUP;
        end
      end
      S_PASS: begin
        src_next = !src;
        if ({w, 1'b0} >= n_ext) begin
          state_next = S_PRIME;
        end else begin
          w_next     = {w[CW-2:0], 1'b0};
          b_next     = '0;
          k_next     = '0;
          state_next = S_SETUP;
        end
      end
      S_PRIME: begin
        k_next     = '0;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        result_valid_next = 1'b1;
        ra_l              = k_inc[AW-1:0];
        k_next            = k_inc;
        if (k_inc == n) begin
          count_next   = '0;
          dropped_next = 1'b0;
          src_next     = 1'b0;
          state_next   = S_LOAD;
        end
      end
      default: state_next = S_LOAD;
    endcase
  end

  // Loads always land in bank 0; merges write the bank opposite the source.
  always_comb begin
    bank0_ctl         = '{we: 1'b0, waddr: wr_addr, wdata: wr_data, raddr_l: ra_l, raddr_r: ra_r};
    bank1_ctl         = bank0_ctl;
    bank0_ctl.we      = wr_en && ((state == S_LOAD) || src);
    bank1_ctl.we      = wr_en && (state == S_MERGE) && !src;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_LOAD;
      count        <= '0;
      dropped      <= 1'b0;
      src          <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      count        <= count_next;
      dropped      <= dropped_next;
      src          <= src_next;
      result_valid <= result_valid_next;
    end
    n           <= n_next;
    w           <= w_next;
    b           <= b_next;
    i           <= i_next;
    j           <= j_next;
    k           <= k_next;
    left_end    <= left_end_next;
    right_end   <= right_end_next;
    sorted_key  <= out_next.key;
    sorted_tag  <= out_next.tag;
    last_result <= last_result_next;
    overflow    <= overflow_next;
  end

endmodule

`default_nettype wire

// ----- rtl/key_tag_merge_sorter.sv -----
// Stable key/tag sorter. Loading: one beat per cycle while busy is low. After the final beat,
// for n pairs: ceil(log2 n) bottom-up merge passes between the two banks, all through the
// single shared comparator; then a prime step and the results, one per clock.
// Synchronous reset empties the store and clears the drop flag that overflow follows;
// results cannot be stalled.
`default_nettype none

module key_tag_merge_sorter (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic signed [ktms_pkg::KEY_W-1:0] key,
  input  wire logic        [ktms_pkg::TAG_W-1:0] tag,
  input  wire logic                              final_item,
  output logic                                   result_valid,
  output logic signed      [ktms_pkg::KEY_W-1:0] sorted_key,
  output logic             [ktms_pkg::TAG_W-1:0] sorted_tag,
  output logic                                   last_result,
  output logic                                   overflow
);

  ktms_pkg::bank_ctl_t bank0_ctl, bank1_ctl;
  ktms_pkg::entry_t    bank0_rd_l, bank0_rd_r, bank1_rd_l, bank1_rd_r;

  ktms_bank u_bank0 (
    .clk  (clk),
    .ctl  (bank0_ctl),
    .rd_l (bank0_rd_l),
    .rd_r (bank0_rd_r)
  );

  ktms_bank u_bank1 (
    .clk  (clk),
    .ctl  (bank1_ctl),
    .rd_l (bank1_rd_l),
    .rd_r (bank1_rd_r)
  );

  ktms_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .key          (key),
    .tag          (tag),
    .final_item   (final_item),
    .busy         (busy),
    .bank0_rd_l   (bank0_rd_l),
    .bank0_rd_r   (bank0_rd_r),
    .bank1_rd_l   (bank1_rd_l),
    .bank1_rd_r   (bank1_rd_r),
    .bank0_ctl    (bank0_ctl),
    .bank1_ctl    (bank1_ctl),
    .result_valid (result_valid),
    .sorted_key   (sorted_key),
    .sorted_tag   (sorted_tag),
    .last_result  (last_result),
    .overflow     (overflow)
  );

endmodule

`default_nettype wire

// ----- rtl/ktms_checker.sv -----
// Port-level checks on the sorter's result sequencing, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none

module ktms_assertions (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire logic result_valid,
  input wire logic last_result,
  input wire logic overflow
);

  // No result in the cycle after a beat is taken.
  a_accept_quiet: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> !result_valid)
    else $error("result strobe right after an accepted beat");

  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    (result_valid && last_result) |-> !busy)
    else $error("still busy on the last result");

  a_mid_busy: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !last_result) |-> busy)
    else $error("ready before the last result");

  // Results of a set follow back to back with one overflow value.
  a_contiguous: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !last_result) |=> (result_valid && $stable(overflow)))
    else $error("gap or overflow change within a result set");

endmodule

bind key_tag_merge_sorter ktms_assertions u_ktms_assertions (.*);

`default_nettype wire
